>>> rtl/core/rsk_pkg.sv
// Package for the record scrambler with keyed checksum.
// Holds the register codes, reset values, the config struct and the key byte table.
// No dependencies.
`timescale 1ns / 1ps

package rsk_pkg;

	localparam int unsigned KeyW    = 16;
	localparam int unsigned SizeW   = 16;
	localparam int unsigned AccW    = 32;
	localparam int unsigned SeedSh  = 9;

	localparam logic [15:0] KeyReset  = 16'hE2F1;
	localparam logic [15:0] SizeReset = 16'd164;
	localparam logic        EnReset   = 1'b1;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_CHECKSUM_KEY = 2'd0,
		REG_RECORD_SIZE  = 2'd1,
		REG_CHECK_ENABLE = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [KeyW-1:0]  checksum_key;
		logic [SizeW-1:0] record_size;
		logic             check_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0]      scrambled_byte;
		logic [AccW-1:0] checksum_value;
		logic            checksum_valid;
		logic            end_of_file;
	} result_t;

	// scramble key byte at a record-relative phase
	function automatic logic [7:0] key_byte(input logic [1:0] phase);
		logic [7:0] kb;
		unique case (phase)
			2'd1:    kb = 8'hCF;
			2'd2:    kb = 8'hAB;
			default: kb = 8'hFC;
		endcase
		return kb;
	endfunction

endpackage

>>> rtl/core/rsk_if.sv
// Stream interfaces for the record scrambler: plaintext requests and result requests.
// Depends on rsk_pkg for the payload widths.
`timescale 1ns / 1ps

interface rsk_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface rsk_result_if;
	import rsk_pkg::*;
	logic            valid;
	logic            ready;
	logic [7:0]      scrambled_byte;
	logic [AccW-1:0] checksum_value;
	logic            checksum_valid;
	logic            end_of_file;

	modport source (output valid, scrambled_byte, checksum_value, checksum_valid,
		end_of_file, input ready);
	modport sink   (input valid, scrambled_byte, checksum_value, checksum_valid,
		end_of_file, output ready);
endinterface

>>> rtl/core/rsk_cfg.sv
// Configuration registers of the record scrambler.
// Depends on rsk_pkg for register codes and reset values.
`timescale 1ns / 1ps

module rsk_cfg
	import rsk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.checksum_key <= KeyReset;
			cfg_q.record_size  <= SizeReset;
			cfg_q.check_enable <= EnReset;
		end else if (cfg_wen) begin
			unique case (reg_index_t'(cfg_index))
				REG_CHECKSUM_KEY: cfg_q.checksum_key <= cfg_data;
				REG_RECORD_SIZE:  cfg_q.record_size  <= cfg_data;
				REG_CHECK_ENABLE: cfg_q.check_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/rsk_engine.sv
// File state and per-byte datapath: scramble, word packing and checksum fold.
// Depends on rsk_pkg for the config and result structs and the key table.
`timescale 1ns / 1ps

module rsk_engine
	import rsk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  cfg_t       cfg,
	output result_t    result
);

	logic [AccW-1:0]  acc_q;
	logic [23:0]      partial_q;
	logic [1:0]       lane_q;
	logic [2:0]       wcount_q;
	logic [1:0]       phase_q;
	logic [SizeW-1:0] pos_q;
	logic             in_file_q;

	logic [AccW-1:0]  seed;
	logic [AccW-1:0]  acc_base;
	logic [7:0]       scr;
	logic [AccW-1:0]  word;
	logic [AccW-1:0]  mixed;
	logic [AccW-1:0]  fold_sum;
	logic [AccW-1:0]  folded;
	logic [AccW-1:0]  acc_next;
	logic [23:0]      partial_next;
	logic [SizeW-1:0] pos_inc;
	logic             rec_end;
	logic             chk_valid;

	// seed taken at the first byte of a file
	assign seed     = {{(AccW-KeyW-SeedSh){1'b0}}, cfg.checksum_key, {SeedSh{1'b0}}};
	assign acc_base = in_file_q ? acc_q : seed;

	// scramble with the record-relative key byte
	assign scr  = data_byte ^ key_byte(phase_q);
	assign word = {scr, partial_q};

	// xor or add, then the fold on every fourth word
	always_comb begin
		if (cfg.checksum_key[0] ^ wcount_q[0])
			mixed = acc_base + word;
		else
			mixed = acc_base ^ word;
		fold_sum = mixed + {{(AccW-KeyW){1'b0}}, cfg.checksum_key};
		if (wcount_q[1:0] == 2'd0)
			folded = mixed ^ (wcount_q[2] ? (fold_sum >> 5) : (fold_sum >> 1));
		else
			folded = mixed;
		acc_next = (lane_q == 2'd3) ? folded : acc_base;
	end

	// pack the byte into its lane of the partial word
	always_comb begin
		partial_next = partial_q;
		unique case (lane_q)
			2'd0:    partial_next[7:0]   = scr;
			2'd1:    partial_next[15:8]  = scr;
			2'd2:    partial_next[23:16] = scr;
			default: partial_next        = '0;
		endcase
	end

	assign pos_inc = pos_q + 1'b1;
	assign rec_end = (pos_inc == cfg.record_size);

	// result of this byte
	assign chk_valid             = last_byte & cfg.check_enable;
	assign result.scrambled_byte = scr;
	assign result.checksum_value = chk_valid ? acc_next : '0;
	assign result.checksum_valid = chk_valid;
	assign result.end_of_file    = last_byte;

	// file state update, cleared on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			partial_q <= '0;
			lane_q    <= '0;
			wcount_q  <= '0;
			phase_q   <= '0;
			pos_q     <= '0;
			in_file_q <= 1'b0;
		end else if (fire) begin
			if (last_byte) begin
				acc_q     <= seed;
				partial_q <= '0;
				lane_q    <= '0;
				wcount_q  <= '0;
				phase_q   <= '0;
				pos_q     <= '0;
				in_file_q <= 1'b0;
			end else begin
				acc_q     <= acc_next;
				partial_q <= partial_next;
				lane_q    <= lane_q + 1'b1;
				in_file_q <= 1'b1;
				if (lane_q == 2'd3)
					wcount_q <= wcount_q + 1'b1;
				if (rec_end) begin
					pos_q   <= '0;
					phase_q <= '0;
				end else begin
					pos_q   <= pos_inc;
					phase_q <= (phase_q >= 2'd2) ? 2'd0 : phase_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/core/record_scramble_keyed_checksum.sv
// Top level of the record scrambler with keyed checksum.
// Depends on rsk_pkg, rsk_if, rsk_cfg and rsk_engine.
//
//   channel    | role   | payload
//   -----------+--------+---------------------------------------------------------
//   plaintext  | sink   | data_byte, last_byte
//   scrambled  | source | scrambled_byte, checksum_value, checksum_valid, end_of_file
//   cfg_*      | write  | cfg_wen, cfg_index, cfg_data
//
// One byte per cycle sustained while the result side is ready. The input register feeds
// the engine, whose result lands in the output register to be offered, and the checksum
// loop (one add or xor, one add, one shift) closes combinationally around acc_q.
// A stalled output holds both registers; plaintext ready drops only when both are full.
// Reset clears the file state and loads the default register values.
`timescale 1ns / 1ps

module record_scramble_keyed_checksum
	import rsk_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	rsk_byte_if.sink      plaintext,
	rsk_result_if.source  scrambled,
	input  logic          cfg_wen,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	cfg_t       cfg;
	result_t    result;
	result_t    out_q;
	logic       out_valid_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       advance;
	logic       fire;

	rsk_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline moves when the output register is free or being taken
	assign advance         = !out_valid_q || scrambled.ready;
	assign fire            = valid_s1 && advance;
	assign plaintext.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (plaintext.ready)
			valid_s1 <= plaintext.valid;
	end

	always_ff @(posedge clk) begin
		if (plaintext.ready && plaintext.valid) begin
			data_s1 <= plaintext.data_byte;
			last_s1 <= plaintext.last_byte;
		end
	end

	rsk_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_q <= result;
	end

	assign scrambled.valid          = out_valid_q;
	assign scrambled.scrambled_byte = out_q.scrambled_byte;
	assign scrambled.checksum_value = out_q.checksum_value;
	assign scrambled.checksum_valid = out_q.checksum_valid;
	assign scrambled.end_of_file    = out_q.end_of_file;

endmodule

>>> verif/rsk_scramble_checker.sv
// Scoreboard for the record scrambler: watches the plaintext, result and register
// write ports, predicts every result request and compares it field by field.
// Depends on rsk_pkg and the stream interfaces in rsk_if.
`timescale 1ns / 1ps

module rsk_scramble_checker
	import rsk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rsk_byte_if         plaintext,
	rsk_result_if       scrambled,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fails,
	output int          pending
);

	localparam logic [7:0] ScrambleKey [3] = '{8'hFC, 8'hCF, 8'hAB};

	// mirrored registers
	logic [15:0] key_cfg;
	logic [15:0] size_cfg;
	logic        enable_cfg;

	// mirrored file state
	logic [31:0] checksum;
	logic [23:0] word_bytes;
	logic [1:0]  lane;
	logic [2:0]  word_index;
	logic [1:0]  key_pos;
	logic [15:0] record_pos;
	logic        file_open;

	result_t expected_results[$];
	int      results_seen;

	task automatic clear_file_state();
		checksum   = 32'(key_cfg) << SeedSh;
		word_bytes = '0;
		lane       = '0;
		word_index = '0;
		key_pos    = '0;
		record_pos = '0;
		file_open  = 1'b0;
	endtask

	// fold one complete little-endian word into the checksum
	task automatic fold_word(input logic [31:0] word);
		logic [31:0] sum;
		if ((key_cfg[0] ^ word_index[0]) == 1'b0)
			checksum = checksum ^ word;
		else
			checksum = checksum + word;
		if (word_index[1:0] == 2'd0) begin
			sum      = checksum + 32'(key_cfg);
			checksum = checksum ^ (sum >> (32'(word_index) + 1));
		end
		word_index = word_index + 3'd1;
	endtask

	// scramble one plaintext byte and work out the result it causes
	task automatic scramble_byte_step(input logic [7:0] plain, input logic last,
		output result_t res);
		logic [1:0]  ph;
		logic [7:0]  scr;
		logic [15:0] next_pos;
		logic        report_sum;
		if (!file_open) begin
			checksum  = 32'(key_cfg) << SeedSh;
			file_open = 1'b1;
		end
		ph  = (key_pos > 2'd2) ? 2'd0 : key_pos;
		scr = plain ^ ScrambleKey[ph];

		if (lane == 2'd3) begin
			fold_word({scr, word_bytes});
			word_bytes = '0;
			lane       = '0;
		end else begin
			word_bytes = word_bytes | (24'(scr) << (8 * lane));
			lane       = lane + 2'd1;
		end

		// key position restarts at each record boundary, size zero wraps at 65536
		next_pos = record_pos + 16'd1;
		if (next_pos == size_cfg) begin
			record_pos = '0;
			key_pos    = '0;
		end else begin
			record_pos = next_pos;
			key_pos    = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
		end

		report_sum         = last & enable_cfg;
		res.scrambled_byte = scr;
		res.checksum_value = report_sum ? checksum : 32'd0;
		res.checksum_valid = report_sum;
		res.end_of_file    = last;
		if (last)
			clear_file_state();
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("result %0d: %s is %h, expected %h", results_seen, field, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			key_cfg    = KeyReset;
			size_cfg   = SizeReset;
			enable_cfg = EnReset;
			clear_file_state();
			expected_results.delete();
			results_seen = 0;
			fails        = 0;
			pending     <= 0;
		end else begin
			// register writes land at this edge
			if (cfg_wen) begin
				case (reg_index_t'(cfg_index))
					REG_CHECKSUM_KEY: key_cfg    = cfg_data;
					REG_RECORD_SIZE:  size_cfg   = cfg_data;
					REG_CHECK_ENABLE: enable_cfg = cfg_data[0];
					default: ;
				endcase
			end

			// accepted plaintext request
			if (plaintext.valid && plaintext.ready) begin
				scramble_byte_step(plaintext.data_byte, plaintext.last_byte, want);
				expected_results.insert(expected_results.size(), want);
			end

			// accepted result request
			if (scrambled.valid && scrambled.ready) begin
				got.scrambled_byte = scrambled.scrambled_byte;
				got.checksum_value = scrambled.checksum_value;
				got.checksum_valid = scrambled.checksum_valid;
				got.end_of_file    = scrambled.end_of_file;
				if (expected_results.size() == 0) begin
					$display("result %0d: arrived with nothing expected", results_seen);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (got.scrambled_byte !== want.scrambled_byte)
						report_mismatch("scrambled_byte", 32'(got.scrambled_byte),
							32'(want.scrambled_byte));
					if (got.checksum_value !== want.checksum_value)
						report_mismatch("checksum_value", got.checksum_value,
							want.checksum_value);
					if (got.checksum_valid !== want.checksum_valid)
						report_mismatch("checksum_valid", 32'(got.checksum_valid),
							32'(want.checksum_valid));
					if (got.end_of_file !== want.end_of_file)
						report_mismatch("end_of_file", 32'(got.end_of_file),
							32'(want.end_of_file));
				end
				results_seen++;
			end
			pending <= expected_results.size();
		end
	end

endmodule

>>> verif/record_scramble_keyed_checksum_tb.sv
// Top of the record scrambler testbench: clock, reset, register writes, plaintext
// and result traffic with random idling, watchdog and verdict.
// Depends on rsk_pkg, rsk_if, the block and rsk_scramble_checker.
`timescale 1ns / 1ps

module record_scramble_keyed_checksum_tb;
	import rsk_pkg::*;

	localparam int ByteTarget    = 1350;
	localparam int CalmAfter     = 1150;
	localparam int HoldCycles    = 60;
	localparam int WatchdogLimit = 2000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wen;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int fails;
	int pending;
	int hold_requests = 0;
	int holds_done    = 0;
	int quiet_cycles  = 0;
	int bytes_sent    = 0;
	bit idling        = 1'b1;

	rsk_byte_if   plaintext();
	rsk_result_if scrambled();

	record_scramble_keyed_checksum i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.plaintext (plaintext),
		.scrambled (scrambled),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rsk_scramble_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.plaintext (plaintext),
		.scrambled (scrambled),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	always #1 clk = ~clk;

	// watchdog on cycles with no request taken on either side
	always @(posedge clk) begin
		if (!arst_n || (plaintext.valid && plaintext.ready) ||
			(scrambled.valid && scrambled.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("record_scramble_keyed_checksum_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random stall bursts and the requested long hold-off
	initial begin
		int stall;
		scrambled.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				stall = HoldCycles;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 4);
			end else begin
				stall = 0;
			end
			if (stall != 0) begin
				scrambled.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			scrambled.ready <= 1'b1;
		end
	end

	// offer one plaintext request and wait until it is taken
	task automatic send_byte(input logic [7:0] plain, input logic last);
		if (idling && $urandom_range(0, 4) == 0) begin
			plaintext.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		plaintext.valid     <= 1'b1;
		plaintext.data_byte <= plain;
		plaintext.last_byte <= last;
		@(posedge clk);
		while (!plaintext.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_file(input int len, input bit close);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
	endtask

	// stop offering and wait until every expected result is back
	task automatic drain();
		plaintext.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int          len;
		int          phase_no;
		int          files;
		logic [15:0] key_val;
		logic [15:0] size_val;

		arst_n              <= 1'b0;
		cfg_wen             <= 1'b0;
		cfg_index           <= REG_CHECKSUM_KEY;
		cfg_data            <= '0;
		plaintext.valid     <= 1'b0;
		plaintext.data_byte <= '0;
		plaintext.last_byte <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: byte extremes, two full words and a one-byte tail
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hC3, 1'b1);
		drain();

		// checksum suppressed, state still clears
		write_reg(REG_CHECK_ENABLE, 16'd0);
		send_file(5, 1'b1);
		drain();

		// one-byte records, key changed in the middle of a file
		write_reg(REG_CHECK_ENABLE, 16'd1);
		write_reg(REG_RECORD_SIZE, 16'd1);
		write_reg(REG_CHECKSUM_KEY, 16'h0000);
		send_file(4, 1'b0);
		drain();
		write_reg(REG_CHECKSUM_KEY, 16'hFFFF);
		send_file(4, 1'b1);
		// file of a single byte, no word completed
		send_byte(8'h3C, 1'b1);
		drain();

		// random phases of mostly well-formed files
		phase_no = 0;
		while (bytes_sent < ByteTarget) begin
			idling = (bytes_sent < CalmAfter) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 5))
				0:       key_val = 16'h0000;
				1:       key_val = 16'hFFFF;
				2:       key_val = KeyReset;
				default: key_val = 16'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 7))
				0:       size_val = 16'd0;
				1:       size_val = 16'hFFFF;
				2:       size_val = 16'd1;
				3:       size_val = 16'($urandom_range(100, 400));
				default: size_val = 16'($urandom_range(2, 12));
			endcase
			write_reg(REG_CHECKSUM_KEY, key_val);
			write_reg(REG_RECORD_SIZE, size_val);
			write_reg(REG_CHECK_ENABLE, 16'($urandom_range(0, 3) != 0));

			// results held back while plaintext keeps coming
			if (phase_no % 12 == 3)
				hold_requests++;

			files = $urandom_range(1, 4);
			for (int f = 0; f < files; f++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 24);
					7, 8:                len = $urandom_range(25, 80);
					default:             len = $urandom_range(81, 300);
				endcase
				// now and then the phase ends with the file still open
				send_file(len, !(f == files - 1 && $urandom_range(0, 5) == 0));
			end
			drain();
			phase_no++;
		end

		// close any open file, then wait out the pipeline
		idling = 1'b0;
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		drain();
		repeat (8) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("record_scramble_keyed_checksum_tb OK");
		else
			$display("record_scramble_keyed_checksum_tb NOT OK");
		$finish;
	end

endmodule
